[rtl/core/dhc_pkg.sv]
`timescale 1ns / 1ps

package dhc_pkg;

   localparam int DispWidth   = 16;
   localparam int MinWidth    = 12;
   localparam int FracBits    = 4;
   localparam int ClampWidth  = 11;
   localparam int HueWidth    = 14;
   localparam int ModWidth    = 12;
   localparam int ChanWidth   = 8;

   // clamp of dq and hue wheel geometry, in 1/1600 sector units
   localparam logic signed [DispWidth-1:0] DqClamp    = 16'sd1600;
   localparam logic [HueWidth-1:0]         HueTop     = 14'd9600;
   localparam logic [HueWidth-1:0]         SectorSpan = 14'd1600;
   localparam logic [ChanWidth-1:0]        ChanFull   = 8'd255;
   localparam logic [ChanWidth-1:0]        ChanOff    = 8'd0;

   // x = floor(v * 255 / 1600) = (v * RampMul) >> RampShift, exact for v <= 1600
   localparam int                RampShift = 20;
   localparam int                ProdWidth = 29;
   localparam logic [17:0]       RampMul   = 18'd167117;

   typedef enum logic [2:0] {
      SECT_0 = 3'd0,
      SECT_1 = 3'd1,
      SECT_2 = 3'd2,
      SECT_3 = 3'd3,
      SECT_4 = 3'd4,
      SECT_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic [ChanWidth-1:0] channel0;
      logic [ChanWidth-1:0] channel1;
      logic [ChanWidth-1:0] channel2;
   } pixel_type;

endpackage

[rtl/core/dhc_map.sv]
`timescale 1ns / 1ps

module dhc_map (
   input  logic signed [dhc_pkg::DispWidth-1:0] disparity,
   input  logic signed [dhc_pkg::MinWidth-1:0]  disp_floor,
   output dhc_pkg::pixel_type                   pixel
);

   logic signed [dhc_pkg::DispWidth-1:0] threshold;
   logic                                 paint;
   logic [dhc_pkg::ClampWidth-1:0]       dq_clamped;
   logic [dhc_pkg::HueWidth-1:0]         dq_times6;
   logic [dhc_pkg::HueWidth-1:0]         hue;
   dhc_pkg::sector_type                  sector;
   logic [dhc_pkg::HueWidth-1:0]         pair_base;
   logic [dhc_pkg::ModWidth-1:0]         hue_mod;
   logic [dhc_pkg::ClampWidth-1:0]       ramp_dev;
   logic [dhc_pkg::ClampWidth-1:0]       ramp_in;
   logic [dhc_pkg::ProdWidth-1:0]        ramp_prod;
   logic [dhc_pkg::ChanWidth-1:0]        ramp;

   // 16 * disp_floor fits exactly in the disparity width
   assign threshold = {disp_floor, {dhc_pkg::FracBits{1'b0}}};
   assign paint     = (disparity > threshold) && (disparity > 16'sd0);

   assign dq_clamped = (disparity > dhc_pkg::DqClamp) ?
                       dhc_pkg::DqClamp[dhc_pkg::ClampWidth-1:0] :
                       disparity[dhc_pkg::ClampWidth-1:0];

   // 6*d as two shifted copies
   assign dq_times6 = {1'b0, dq_clamped, 2'b00} + {2'b00, dq_clamped, 1'b0};
   assign hue       = dhc_pkg::HueTop - dq_times6;

   // sector by compare ladder
   always_comb begin
      if (hue >= dhc_pkg::HueWidth'(5 * dhc_pkg::SectorSpan)) begin
         sector = dhc_pkg::SECT_5;
      end else if (hue >= dhc_pkg::HueWidth'(4 * dhc_pkg::SectorSpan)) begin
         sector = dhc_pkg::SECT_4;
      end else if (hue >= dhc_pkg::HueWidth'(3 * dhc_pkg::SectorSpan)) begin
         sector = dhc_pkg::SECT_3;
      end else if (hue >= dhc_pkg::HueWidth'(2 * dhc_pkg::SectorSpan)) begin
         sector = dhc_pkg::SECT_2;
      end else if (hue >= dhc_pkg::SectorSpan) begin
         sector = dhc_pkg::SECT_1;
      end else begin
         sector = dhc_pkg::SECT_0;
      end
   end

   // hue mod 3200 from the sector pair
   assign pair_base = sector[2] ? dhc_pkg::HueWidth'(4 * dhc_pkg::SectorSpan) :
                      sector[1] ? dhc_pkg::HueWidth'(2 * dhc_pkg::SectorSpan) : '0;
   assign hue_mod   = dhc_pkg::ModWidth'(hue - pair_base);

   always_comb begin
      if (hue_mod >= dhc_pkg::ModWidth'(dhc_pkg::SectorSpan)) begin
         ramp_dev = dhc_pkg::ClampWidth'(hue_mod - dhc_pkg::ModWidth'(dhc_pkg::SectorSpan));
      end else begin
         ramp_dev = dhc_pkg::ClampWidth'(dhc_pkg::ModWidth'(dhc_pkg::SectorSpan) - hue_mod);
      end
   end

   assign ramp_in   = dhc_pkg::ClampWidth'(dhc_pkg::SectorSpan) - ramp_dev;
   assign ramp_prod = dhc_pkg::ProdWidth'(ramp_in * dhc_pkg::RampMul);
   assign ramp      = ramp_prod[dhc_pkg::RampShift +: dhc_pkg::ChanWidth];

   always_comb begin
      pixel.channel0 = dhc_pkg::ChanOff;
      pixel.channel1 = dhc_pkg::ChanOff;
      pixel.channel2 = dhc_pkg::ChanOff;
      if (paint) begin
         case (sector)
            dhc_pkg::SECT_0: begin
               pixel.channel0 = dhc_pkg::ChanFull;
               pixel.channel1 = ramp;
            end
            dhc_pkg::SECT_1: begin
               pixel.channel0 = ramp;
               pixel.channel1 = dhc_pkg::ChanFull;
            end
            dhc_pkg::SECT_2: begin
               pixel.channel1 = dhc_pkg::ChanFull;
               pixel.channel2 = ramp;
            end
            dhc_pkg::SECT_3: begin
               pixel.channel1 = ramp;
               pixel.channel2 = dhc_pkg::ChanFull;
            end
            dhc_pkg::SECT_4: begin
               pixel.channel0 = ramp;
               pixel.channel2 = dhc_pkg::ChanFull;
            end
            default: begin
               pixel.channel0 = dhc_pkg::ChanFull;
               pixel.channel2 = ramp;
            end
         endcase
      end
   end

endmodule

[rtl/core/disparity_hue_colorizer.sv]
// disparity to false color on a hue wheel, one pixel per transaction
// an accepted request is registered in the input stage, then in the result register that drives rsp_valid
// throughput: one transaction per cycle while rsp_stall stays low
// reset: synchronous active high; clears both stage valids and the disparity floor to 0
// the color math is one constant multiply plus adds, subtracts and compares between the two registers
`timescale 1ns / 1ps

module disparity_hue_colorizer (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [dhc_pkg::MinWidth-1:0]          csr_wr_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dhc_pkg::DispWidth-1:0]  req_disparity,
   input  logic                                  req_end_of_frame,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dhc_pkg::ChanWidth-1:0]         rsp_channel0,
   output logic [dhc_pkg::ChanWidth-1:0]         rsp_channel1,
   output logic [dhc_pkg::ChanWidth-1:0]         rsp_channel2,
   output logic                                  rsp_frame_last
);

   // configuration register
   logic signed [dhc_pkg::MinWidth-1:0]  min_disp_ff;

   // input stage
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   logic signed [dhc_pkg::DispWidth-1:0] s1_disparity_ff;
   logic                                 s1_eof_ff;

   // result stage
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   dhc_pkg::pixel_type                   rsp_pixel_ff;
   logic                                 rsp_eof_ff;

   dhc_pkg::pixel_type                   pixel;
   logic                                 out_advance;
   logic                                 req_take;

   // result stage loads when empty or when its transaction leaves this cycle
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   // input stage frees up when it is empty or moves into the result stage
   assign req_stall   = s1_valid_ff && !out_advance;
   assign req_take    = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_advance);
   assign rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_disp_ff <= '0;
      end else if (csr_wr_en) begin
         min_disp_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: input stage captures on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_disparity_ff <= req_disparity;
         s1_eof_ff       <= req_end_of_frame;
      end
   end

   // color mapping between the two registers
   dhc_map u_map (
      .disparity  (s1_disparity_ff),
      .disp_floor (min_disp_ff),
      .pixel      (pixel)
   );

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_pixel_ff <= pixel;
         rsp_eof_ff   <= s1_eof_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel0   = rsp_pixel_ff.channel0;
   assign rsp_channel1   = rsp_pixel_ff.channel1;
   assign rsp_channel2   = rsp_pixel_ff.channel2;
   assign rsp_frame_last = rsp_eof_ff;

   // an accepted request always lands in the input stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost before input stage");

   // a stall toward the requester only while the input stage is occupied
   a_stall_occupied: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input stage");

   // an item that moves on shows up as a result next cycle
   a_move_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_advance) |=> rsp_valid_ff)
      else $error("input stage moved but no result");

   // non-positive disparity gives a black pixel
   a_black: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_advance && !(s1_disparity_ff > 16'sd0)) |=>
      (rsp_channel0 == 8'd0 && rsp_channel1 == 8'd0 && rsp_channel2 == 8'd0))
      else $error("non-positive disparity not painted black");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   // run limits and stimulus sizes
   localparam int MaxCycles  = 200000;
   localparam int NumCases   = 22;
   localparam int NumPhases  = 5;
   localparam int PhaseItems = 320;
   localparam int DrainDelay = 4;

   // hue wheel geometry, in 1/1600 sector units
   localparam int ClampLimit = 1600;
   localparam int WheelTop   = 9600;
   localparam int SectorLen  = 1600;

   // one colored pixel as the result channel delivers it
   typedef struct packed {
      logic [dhc_pkg::ChanWidth-1:0] c0;
      logic [dhc_pkg::ChanWidth-1:0] c1;
      logic [dhc_pkg::ChanWidth-1:0] c2;
      logic                          last;
   } bgr_pixel_type;

   // one row of the directed table; typed rows carry the color read off by hand
   typedef struct packed {
      logic [dhc_pkg::DispWidth-1:0] disp;
      logic                          eof;
      logic                          typed;
      logic [dhc_pkg::ChanWidth-1:0] c0;
      logic [dhc_pkg::ChanWidth-1:0] c1;
      logic [dhc_pkg::ChanWidth-1:0] c2;
   } pixel_case_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_wr_en;
   logic [dhc_pkg::MinWidth-1:0]         csr_wr_data;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [dhc_pkg::DispWidth-1:0] req_disparity;
   logic                                 req_end_of_frame;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [dhc_pkg::ChanWidth-1:0]        rsp_channel0;
   logic [dhc_pkg::ChanWidth-1:0]        rsp_channel1;
   logic [dhc_pkg::ChanWidth-1:0]        rsp_channel2;
   logic                                 rsp_frame_last;

   // colors owed by the block, oldest first
   bgr_pixel_type expected_colors[$];

   // shadow of the disparity floor as last written
   logic signed [dhc_pkg::MinWidth-1:0] floor_px;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   bit quiet          = 1'b0;

   // idling per phase and the disparity floor written before it
   int phase_gap   [NumPhases] = '{0, 80, 0, 34, 0};
   int phase_stall [NumPhases] = '{0, 0, 80, 34, 0};
   int phase_floor [NumPhases] = '{-2048, 25, 2047, 0, 0};

   // directed part, run with the disparity floor at its reset value of zero
   pixel_case_type directed_cases [NumCases] = '{
      '{16'h8000, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0  },  // most negative: black
      '{16'hFFFF, 1'b1, 1'b1, 8'd0,   8'd0,   8'd0  },  // -1/16 pixel: black, eof kept
      '{16'd0,    1'b0, 1'b1, 8'd0,   8'd0,   8'd0  },  // zero sits on the threshold
      '{16'h7FFF, 1'b1, 1'b1, 8'd255, 8'd0,   8'd0  },  // most positive clamps to h = 0
      '{16'd1600, 1'b0, 1'b1, 8'd255, 8'd0,   8'd0  },  // exactly at the clamp
      '{16'd1601, 1'b0, 1'b1, 8'd255, 8'd0,   8'd0  },  // just past the clamp
      '{16'd800,  1'b0, 1'b1, 8'd0,   8'd255, 8'd255},  // ramp peak in sector 3
      '{16'd1,    1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },  // smallest colored pixel
      '{16'd100,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd266,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },  // last of sector 5
      '{16'd267,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0  },  // first of sector 4
      '{16'd400,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd533,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd534,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },  // into sector 3
      '{16'd700,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd1000, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd1066, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd1067, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0  },  // into sector 1
      '{16'd1300, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd1333, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd1334, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0  },  // into sector 0
      '{16'd1500, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0  }
   };

   disparity_hue_colorizer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_disparity    (req_disparity),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel0     (rsp_channel0),
      .rsp_channel1     (rsp_channel1),
      .rsp_channel2     (rsp_channel2),
      .rsp_frame_last   (rsp_frame_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hue wheel color of one disparity pixel under a given disparity floor
   function automatic bgr_pixel_type colorize(
         input logic signed [dhc_pkg::DispWidth-1:0] dq,
         input logic signed [dhc_pkg::MinWidth-1:0]  floor_val,
         input logic                                 eof);
      bgr_pixel_type       px;
      int                  d;
      int                  hue;
      int                  m;
      int                  dev;
      int                  x;
      dhc_pkg::sector_type sect;
      px = '{8'd0, 8'd0, 8'd0, eof};
      d  = dq;
      // black at or below the floor, and for zero or negative disparity
      if (d > 16 * int'(floor_val) && d > 0) begin
         if (d > ClampLimit) d = ClampLimit;
         hue  = WheelTop - 6 * d;
         sect = dhc_pkg::sector_type'(hue / SectorLen);
         m    = hue % (2 * SectorLen);
         dev  = m - SectorLen;
         if (dev < 0) dev = -dev;
         // triangle ramp, rounded down
         x = (SectorLen - dev) * 255 / SectorLen;
         case (sect)
            dhc_pkg::SECT_0: begin
               px.c0 = 8'd255;
               px.c1 = 8'(x);
            end
            dhc_pkg::SECT_1: begin
               px.c0 = 8'(x);
               px.c1 = 8'd255;
            end
            dhc_pkg::SECT_2: begin
               px.c1 = 8'd255;
               px.c2 = 8'(x);
            end
            dhc_pkg::SECT_3: begin
               px.c1 = 8'(x);
               px.c2 = 8'd255;
            end
            dhc_pkg::SECT_4: begin
               px.c0 = 8'(x);
               px.c2 = 8'd255;
            end
            default: begin
               px.c0 = 8'd255;
               px.c2 = 8'(x);
            end
         endcase
      end
      return px;
   endfunction

   // random disparity: mostly on the colored range, some near the floor, some anywhere
   function automatic logic [dhc_pkg::DispWidth-1:0] pick_disparity(input int floor_val);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 16'($urandom);
      if (r < 30) return 16'(16 * floor_val + int'($urandom_range(0, 6)) - 3);
      return 16'($urandom_range(1, 1700));
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // one request transaction; valid stays up afterward unless the next call idles
   task automatic send_pixel(input logic [dhc_pkg::DispWidth-1:0] disp, input logic eof,
                             input logic typed, input bgr_pixel_type typed_px);
      while (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_disparity    <= disp;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      if (typed) expected_colors.insert(expected_colors.size(), typed_px);
      else expected_colors.insert(expected_colors.size(), colorize(disp, floor_px, eof));
   endtask

   // hold the sender off until every owed color has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
   endtask

   // the disparity floor is only written with the pipeline empty
   task automatic write_floor(input int floor_val);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dhc_pkg::MinWidth'(floor_val);
      @(posedge clock);
      floor_px = dhc_pkg::MinWidth'(floor_val);
      csr_wr_en <= 1'b0;
   endtask

   // receiver stall, random per cycle unless in a quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && stall_pct != 0 && ($urandom_range(0, 99) < stall_pct);
   end

   // response check against the oldest owed color
   always @(posedge clock) begin : check_rsp
      bgr_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $display("%0t: unexpected pixel %0d %0d %0d last %0d", $time,
                     rsp_channel0, rsp_channel1, rsp_channel2, rsp_frame_last);
            mismatch_count++;
         end else begin
            want = expected_colors.pop_front();
            check_field("channel0", want.c0, rsp_channel0);
            check_field("channel1", want.c1, rsp_channel1);
            check_field("channel2", want.c2, rsp_channel2);
            check_field("frame_last", want.last, rsp_frame_last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycles) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      pixel_case_type row;
      int             phase;
      int             k;
      int             floor_val;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_valid        <= 1'b0;
      req_disparity    <= '0;
      req_end_of_frame <= 1'b0;
      floor_px = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling, reset value of the disparity floor
      for (k = 0; k < NumCases; k++) begin
         row = directed_cases[k];
         send_pixel(row.disp, row.eof, row.typed, '{row.c0, row.c1, row.c2, row.eof});
      end

      // random phases: new floor and new idling in each, quiet stretches inside
      for (phase = 0; phase < NumPhases; phase++) begin
         floor_val = phase_floor[phase];
         if (phase == 3) floor_val = int'($urandom_range(0, 80)) - 20;
         write_floor(floor_val);
         gap_pct   = phase_gap[phase];
         stall_pct = phase_stall[phase];
         for (k = 0; k < PhaseItems; k++) begin
            quiet = ((k / 40) % 4) == 3;
            // sender holds off mid-phase until the block has emptied
            if (phase == 2 && k == PhaseItems / 2) drain();
            send_pixel(pick_disparity(floor_val), $urandom_range(0, 15) == 0, 1'b0, '0);
         end
      end

      drain();
      quiet     = 1'b1;
      stall_pct = 0;
      repeat (DrainDelay) @(posedge clock);
      if (mismatch_count == 0 && expected_colors.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
